### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that an expression is never true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/tdqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop queue monitor package
// Field widths, constants and sequencer types of the queue monitor.
// ----------------------------------------------------------------------------
package tdqm_pkg;

   localparam int CountWidth   = 11;   // occupancy, capacity, peak, average
   localparam int DropWidth    = 10;   // arrivals, departures, dropped
   localparam int TotalWidth   = 32;   // saturating totals and tick count
   localparam int SumWidth     = 48;   // occupancy sum
   localparam int LossWidth    = 18;
   localparam int FullWidth    = 15;
   localparam int FracBits     = 8;
   localparam int ProdWidth    = 55;   // occupancy sum times percent scale
   localparam int DenWidth     = 43;   // tick count times capacity
   localparam int QuoWidth     = 18;   // widest quotient kept
   localparam int StepWidth    = 6;    // division step counter
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 176;

   localparam logic [CountWidth-1:0] CapacityReset = 11'd100;
   localparam logic [CountWidth-1:0] PercentScale  = 11'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DEN,
      ST_MUL_NUM,
      ST_LOAD_AVG,
      ST_LOAD_LOSS,
      ST_LOAD_FULL,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_AVG,
      DIV_LOSS,
      DIV_FULL
   } div_type;

endpackage

### hw/rtl/tail_drop_queue_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop queue monitor
// Tracks a tail-drop queue tick by tick and reports occupancy statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on req_* is one tick: arrivals and departures offered to a
//   modeled queue. The tick updates occupancy, peak, drop and event totals,
//   the occupancy sum and the tick count in the cycle it is accepted. A
//   bit-serial sequencer then forms tick count times capacity and occupancy
//   sum times 100 (shift-and-add, one multiplier bit per cycle) and runs
//   three restoring divisions, one quotient bit per cycle, on one shared
//   divider: average (48 steps), loss rate (18 steps) and fullness (15
//   steps). Loss rate and fullness are checked for saturation before they run.
//   One request is in work at a time, so a new request is taken only after
//   the previous result has moved to the output register; the work is
//   shorter when capacity is small or a ratio saturates.
//   A result waits in the output register while the next request is already
//   accepted and worked on; a stalled receiver only holds back the hand-off
//   of the following result.
//   csr_wr_en writes queue capacity (0 acts as 1, values above MAX_CAPACITY
//   are clamped). Reset clears all statistics and sets capacity to 100.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tail_drop_queue_monitor #(
   parameter int unsigned MAX_CAPACITY = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // arrivals [9:0], departures [19:10], zero [23:20]
   input  logic [tdqm_pkg::ReqDataWidth-1:0]    req_tdata,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // occupancy [10:0], overflow_now [11], underflow_now [12],
   // dropped_now [22:13], max_occupancy [33:23], total_lost [65:34],
   // overflow_events [97:66], underflow_events [129:98],
   // avg_occupancy [140:130], loss_rate_q8 [158:141],
   // fullness_q8 [173:159], zero [175:174]
   output logic [tdqm_pkg::RspDataWidth-1:0]    rsp_tdata,
   // capacity register
   input  logic                                 csr_wr_en,
   input  logic [tdqm_pkg::CountWidth-1:0]      csr_wr_data
);

   localparam logic [16:0] MaxCap = 17'(MAX_CAPACITY);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   tdqm_pkg::state_type  state_ff, state_in;
   tdqm_pkg::div_type    div_kind_ff, div_kind_in;

   logic [10:0] cap_ff;

   // queue statistics
   logic [10:0] held_ff,      held_in;
   logic [10:0] peak_ff,      peak_in;
   logic [31:0] lost_ff,      lost_in;
   logic [31:0] ovf_total_ff, ovf_total_in;
   logic [31:0] unf_total_ff, unf_total_in;
   logic [47:0] sum_ff,       sum_in;
   logic [31:0] tick_ff,      tick_in;

   // per-tick results held until hand-off
   logic        ovf_ff,     ovf_in;
   logic        unf_ff,     unf_in;
   logic [9:0]  dropped_ff, dropped_in;

   // shift-and-add multiplier
   logic [54:0] acc_ff,      acc_in;
   logic [54:0] mcand_ff,    mcand_in;
   logic [10:0] mplier_ff,   mplier_in;
   logic [42:0] den_full_ff, den_full_in;

   // restoring divider
   logic [42:0] rem_ff,  rem_in;
   logic [42:0] den_ff,  den_in;
   logic [47:0] num_ff,  num_in;
   logic [17:0] quo_ff,  quo_in;
   logic [5:0]  step_ff, step_in;

   // ratios
   logic [10:0] avg_ff,  avg_in;
   logic [17:0] loss_ff, loss_in;
   logic [14:0] full_ff, full_in;

   // output register
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [tdqm_pkg::RspDataWidth-1:0]   rsp_tdata_ff,  rsp_tdata_in;

   // ------------------------------------------------------------------------
   // Tick update, done in the accepting cycle
   // ------------------------------------------------------------------------
   logic        req_fire;
   logic [9:0]  arrivals;
   logic [9:0]  departures;
   logic [10:0] cap_used;
   logic [11:0] offered;
   logic [10:0] room;
   logic [10:0] mid_count;
   logic        tick_ovf;
   logic        tick_unf;
   logic [9:0]  tick_dropped;
   logic [10:0] held_next;
   logic [32:0] lost_sum;
   logic [48:0] sum_wide;

   assign req_fire   = req_tvalid && req_tready;
   assign arrivals   = req_tdata[9:0];
   assign departures = req_tdata[19:10];

   // clamp capacity to 1..MAX_CAPACITY
   always_comb begin
      if (cap_ff == '0) begin
         cap_used = 11'd1;
      end else if ({6'b0, cap_ff} > MaxCap) begin
         cap_used = MaxCap[10:0];
      end else begin
         cap_used = cap_ff;
      end
   end

   always_comb begin
      offered  = {1'b0, held_ff} + {2'b0, arrivals};
      tick_ovf = offered > {1'b0, cap_used};
      room     = (held_ff >= cap_used) ? '0 : (cap_used - held_ff);
      if (tick_ovf) begin
         // room is below arrivals here: drop the rest, keep what fits
         tick_dropped = arrivals - room[9:0];
         mid_count    = held_ff + room;
      end else begin
         tick_dropped = '0;
         mid_count    = offered[10:0];
      end
      tick_unf  = {1'b0, departures} > mid_count;
      held_next = tick_unf ? '0 : (mid_count - {1'b0, departures});
      lost_sum  = {1'b0, lost_ff} + {23'b0, tick_dropped};
      sum_wide  = {1'b0, sum_ff} + {38'b0, held_next};

      held_in      = held_ff;
      peak_in      = peak_ff;
      lost_in      = lost_ff;
      ovf_total_in = ovf_total_ff;
      unf_total_in = unf_total_ff;
      sum_in       = sum_ff;
      tick_in      = tick_ff;
      ovf_in       = ovf_ff;
      unf_in       = unf_ff;
      dropped_in   = dropped_ff;

      if (req_fire) begin
         held_in    = held_next;
         peak_in    = (held_next > peak_ff) ? held_next : peak_ff;
         lost_in    = lost_sum[32] ? '1 : lost_sum[31:0];
         sum_in     = sum_wide[48] ? '1 : sum_wide[47:0];
         tick_in    = (&tick_ff) ? tick_ff : (tick_ff + 32'd1);
         ovf_in     = tick_ovf;
         unf_in     = tick_unf;
         dropped_in = tick_dropped;
         if (tick_ovf && !(&ovf_total_ff)) begin
            ovf_total_in = ovf_total_ff + 32'd1;
         end
         if (tick_unf && !(&unf_total_ff)) begin
            unf_total_in = unf_total_ff + 32'd1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer and serial datapath
   // ------------------------------------------------------------------------
   logic [43:0] div_trial;
   logic        div_ge;
   logic [43:0] div_diff;
   logic [21:0] loss_high;
   logic        loss_sat;
   logic [47:0] full_high;
   logic        full_sat;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, num_ff[47]};
   assign div_ge    = div_trial >= {1'b0, den_ff};
   assign div_diff  = div_trial - {1'b0, den_ff};

   // quotient overflows its field exactly when dividend >> width >= divisor
   assign loss_high = lost_ff[31:10];
   assign loss_sat  = {10'b0, loss_high} >= tick_ff;
   assign full_high = acc_ff[54:7];
   assign full_sat  = full_high >= {5'b0, den_full_ff};

   always_comb begin
      state_in      = state_ff;
      div_kind_in   = div_kind_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      den_full_in   = den_full_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      avg_in        = avg_ff;
      loss_in       = loss_ff;
      full_in       = full_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = 1'b0;

      unique case (state_ff)
         tdqm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               // start tick count times capacity
               acc_in    = '0;
               mcand_in  = {23'b0, tick_in};
               mplier_in = cap_used;
               state_in  = tdqm_pkg::ST_MUL_DEN;
            end
         end

         tdqm_pkg::ST_MUL_DEN: begin
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[53:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[10:1]};
            end else begin
               // hold the denominator, start occupancy sum times 100
               den_full_in = acc_ff[42:0];
               acc_in      = '0;
               mcand_in    = {7'b0, sum_ff};
               mplier_in   = tdqm_pkg::PercentScale;
               state_in    = tdqm_pkg::ST_MUL_NUM;
            end
         end

         tdqm_pkg::ST_MUL_NUM: begin
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[53:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[10:1]};
            end else begin
               state_in = tdqm_pkg::ST_LOAD_AVG;
            end
         end

         tdqm_pkg::ST_LOAD_AVG: begin
            rem_in      = '0;
            num_in      = sum_ff;
            den_in      = {11'b0, tick_ff};
            step_in     = 6'(tdqm_pkg::SumWidth);
            div_kind_in = tdqm_pkg::DIV_AVG;
            state_in    = tdqm_pkg::ST_DIV_RUN;
         end

         tdqm_pkg::ST_LOAD_LOSS: begin
            if (loss_sat) begin
               loss_in  = '1;
               state_in = tdqm_pkg::ST_LOAD_FULL;
            end else begin
               rem_in      = {21'b0, loss_high};
               num_in      = {lost_ff[9:0], 38'b0};
               den_in      = {11'b0, tick_ff};
               step_in     = 6'(tdqm_pkg::LossWidth);
               div_kind_in = tdqm_pkg::DIV_LOSS;
               state_in    = tdqm_pkg::ST_DIV_RUN;
            end
         end

         tdqm_pkg::ST_LOAD_FULL: begin
            if (full_sat) begin
               full_in  = '1;
               state_in = tdqm_pkg::ST_DONE;
            end else begin
               rem_in      = full_high[42:0];
               num_in      = {acc_ff[6:0], 8'b0, 33'b0};
               den_in      = den_full_ff;
               step_in     = 6'(tdqm_pkg::FullWidth);
               div_kind_in = tdqm_pkg::DIV_FULL;
               state_in    = tdqm_pkg::ST_DIV_RUN;
            end
         end

         tdqm_pkg::ST_DIV_RUN: begin
            if (step_ff != '0) begin
               rem_in  = div_ge ? div_diff[42:0] : div_trial[42:0];
               quo_in  = {quo_ff[16:0], div_ge};
               num_in  = {num_ff[46:0], 1'b0};
               step_in = step_ff - 6'd1;
            end else begin
               unique case (div_kind_ff)
                  tdqm_pkg::DIV_AVG: begin
                     avg_in   = quo_ff[10:0];
                     state_in = tdqm_pkg::ST_LOAD_LOSS;
                  end
                  tdqm_pkg::DIV_LOSS: begin
                     loss_in  = quo_ff;
                     state_in = tdqm_pkg::ST_LOAD_FULL;
                  end
                  tdqm_pkg::DIV_FULL: begin
                     full_in  = quo_ff[14:0];
                     state_in = tdqm_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = tdqm_pkg::ST_DONE;
                  end
               endcase
            end
         end

         tdqm_pkg::ST_DONE: begin
            // hand off once the output register is free or being drained
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b0, full_ff, loss_ff, avg_ff, unf_total_ff,
                                ovf_total_ff, lost_ff, peak_ff, dropped_ff,
                                unf_ff, ovf_ff, held_ff};
               state_in      = tdqm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tdqm_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Clocked blocks
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdqm_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         cap_ff        <= tdqm_pkg::CapacityReset;
         held_ff       <= '0;
         peak_ff       <= '0;
         lost_ff       <= '0;
         ovf_total_ff  <= '0;
         unf_total_ff  <= '0;
         sum_ff        <= '0;
         tick_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         held_ff       <= held_in;
         peak_ff       <= peak_in;
         lost_ff       <= lost_in;
         ovf_total_ff  <= ovf_total_in;
         unf_total_ff  <= unf_total_in;
         sum_ff        <= sum_in;
         tick_ff       <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      div_kind_ff  <= div_kind_in;
      ovf_ff       <= ovf_in;
      unf_ff       <= unf_in;
      dropped_ff   <= dropped_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      den_full_ff  <= den_full_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      avg_ff       <= avg_in;
      loss_ff      <= loss_in;
      full_ff      <= full_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_HOLDS(a_peak_covers_held, clock, reset,
      peak_ff >= held_ff, "peak below occupancy")
   `ASSERT_HOLDS(a_rem_below_den, clock, reset,
      (state_ff == tdqm_pkg::ST_DIV_RUN) |-> (rem_ff < den_ff),
      "divider remainder not below divisor")
   `ASSERT_HOLDS(a_drop_means_ovf, clock, reset,
      (state_ff == tdqm_pkg::ST_DONE && dropped_ff != '0) |-> ovf_ff,
      "drop without overflow flag")
   `ASSERT_HOLDS(a_unf_empties, clock, reset,
      (state_ff == tdqm_pkg::ST_DONE && unf_ff) |-> (held_ff == '0),
      "underflow left packets held")
   `ASSERT_HOLDS(a_rsp_from_done, clock, reset,
      $rose(rsp_tvalid_ff) |-> $past(state_ff == tdqm_pkg::ST_DONE),
      "result raised outside hand-off")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop queue monitor testbench
// Drives queue ticks (arrivals, departures) into the monitor and checks every
// statistics report against a local predictor of the queue. A short directed
// table covers the field extremes, exact fills, exact drains, underflows and a
// capacity lowered below the held count. Random ticks then follow under
// several capacity settings and three idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          MaxCapacity   = 1024;
   localparam int          QuietLimit    = 4000;  // cycles with no handshake
   localparam int          SettleCycles  = 150;   // beyond the worst latency
   localparam int          LongStall     = 800;
   localparam int          SubPhaseTicks = 104;
   localparam int          MaxPrinted    = 30;
   localparam longint unsigned Sat32     = 64'hFFFF_FFFF;
   localparam longint unsigned Sat48     = 64'hFFFF_FFFF_FFFF;

   typedef enum logic {
      ROW_TICK,
      ROW_SET_CAPACITY
   } row_kind_type;

   // one directed row: a tick (a = arrivals, b = departures) or a capacity write
   typedef struct {
      row_kind_type kind;
      int unsigned  a;
      int unsigned  b;
      bit           known;
      int unsigned  occ;
      bit           ovf;
      bit           unf;
      int unsigned  dropped;
   } stim_row_type;

   // fields typed into a directed row, applied to that tick's report
   typedef struct {
      bit                                known;
      logic [tdqm_pkg::CountWidth-1:0]   occ;
      logic                              ovf;
      logic                              unf;
      logic [tdqm_pkg::DropWidth-1:0]    dropped;
   } typed_fields_type;

   typedef struct {
      logic [tdqm_pkg::CountWidth-1:0]   occupancy;
      logic                              overflow_now;
      logic                              underflow_now;
      logic [tdqm_pkg::DropWidth-1:0]    dropped_now;
      logic [tdqm_pkg::CountWidth-1:0]   max_occupancy;
      logic [tdqm_pkg::TotalWidth-1:0]   total_lost;
      logic [tdqm_pkg::TotalWidth-1:0]   overflow_events;
      logic [tdqm_pkg::TotalWidth-1:0]   underflow_events;
      logic [tdqm_pkg::CountWidth-1:0]   avg_occupancy;
      logic [tdqm_pkg::LossWidth-1:0]    loss_rate_q8;
      logic [tdqm_pkg::FullWidth-1:0]    fullness_q8;
   } tick_report_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [tdqm_pkg::ReqDataWidth-1:0]   req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [tdqm_pkg::RspDataWidth-1:0]   rsp_tdata;
   logic                                csr_wr_en;
   logic [tdqm_pkg::CountWidth-1:0]     csr_wr_data;

   tail_drop_queue_monitor #(
      .MAX_CAPACITY(MaxCapacity)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // --------------------------------------------------------------------------
   // Clock
   // --------------------------------------------------------------------------
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // --------------------------------------------------------------------------
   // Queue predictor state: mirrors the monitor's statistics registers
   // --------------------------------------------------------------------------
   logic [tdqm_pkg::CountWidth-1:0] q_capacity;
   longint unsigned       q_held;
   longint unsigned       q_peak;
   longint unsigned       q_lost;
   longint unsigned       q_ovf_ticks;
   longint unsigned       q_unf_ticks;
   longint unsigned       q_occ_sum;
   longint unsigned       q_ticks;

   tick_report_type       expected_reports[$];
   typed_fields_type      typed_fields_q[$];
   int                    requests_taken;
   int                    reports_checked;
   int                    mismatches;
   int                    capacity_writes;
   int                    send_idle_pct;
   int                    rsp_idle_pct;
   int                    long_stalls_asked;

   // Capacity actually in force: zero acts as one, large values are clamped.
   function automatic longint unsigned capacity_in_force();
      if (q_capacity == '0)
         return 64'd1;
      if (q_capacity > MaxCapacity)
         return 64'(MaxCapacity);
      return 64'(q_capacity);
   endfunction

   // Apply one tick to the modeled queue and return the report it produces.
   function automatic tick_report_type advance_queue_stats(
         logic [tdqm_pkg::DropWidth-1:0] arr,
         logic [tdqm_pkg::DropWidth-1:0] dep);
      tick_report_type r;
      longint unsigned cap;
      longint unsigned held;
      longint unsigned accepted;
      longint unsigned dropped;
      longint unsigned loss;
      longint unsigned full;
      bit              ovf;
      bit              unf;
      cap      = capacity_in_force();
      held     = q_held;
      accepted = 64'(arr);
      dropped  = 64'd0;
      ovf      = 1'b0;
      unf      = 1'b0;
      // arrivals first: whatever does not fit is dropped
      if (held + 64'(arr) > cap) begin
         ovf      = 1'b1;
         accepted = (held >= cap) ? 64'd0 : cap - held;
         dropped  = 64'(arr) - accepted;
      end
      held += accepted;
      // then departures: asking for more than is held empties the queue
      if (64'(dep) > held) begin
         unf  = 1'b1;
         held = 64'd0;
      end else begin
         held -= 64'(dep);
      end
      q_held = held;
      if (held > q_peak)
         q_peak = held;
      q_lost      = (q_lost + dropped > Sat32) ? Sat32 : q_lost + dropped;
      q_ovf_ticks = (ovf && q_ovf_ticks < Sat32) ? q_ovf_ticks + 64'd1 : q_ovf_ticks;
      q_unf_ticks = (unf && q_unf_ticks < Sat32) ? q_unf_ticks + 64'd1 : q_unf_ticks;
      q_occ_sum   = (q_occ_sum + held > Sat48) ? Sat48 : q_occ_sum + held;
      q_ticks     = (q_ticks < Sat32) ? q_ticks + 64'd1 : q_ticks;

      loss = (q_lost << tdqm_pkg::FracBits) / q_ticks;
      if (loss > (64'd1 << tdqm_pkg::LossWidth) - 64'd1)
         loss = (64'd1 << tdqm_pkg::LossWidth) - 64'd1;
      full = (q_occ_sum * (64'(tdqm_pkg::PercentScale) << tdqm_pkg::FracBits))
             / (q_ticks * cap);
      if (full > (64'd1 << tdqm_pkg::FullWidth) - 64'd1)
         full = (64'd1 << tdqm_pkg::FullWidth) - 64'd1;

      r.occupancy        = held[tdqm_pkg::CountWidth-1:0];
      r.overflow_now     = ovf;
      r.underflow_now    = unf;
      r.dropped_now      = dropped[tdqm_pkg::DropWidth-1:0];
      r.max_occupancy    = q_peak[tdqm_pkg::CountWidth-1:0];
      r.total_lost       = q_lost[tdqm_pkg::TotalWidth-1:0];
      r.overflow_events  = q_ovf_ticks[tdqm_pkg::TotalWidth-1:0];
      r.underflow_events = q_unf_ticks[tdqm_pkg::TotalWidth-1:0];
      r.avg_occupancy    = tdqm_pkg::CountWidth'(q_occ_sum / q_ticks);
      r.loss_rate_q8     = loss[tdqm_pkg::LossWidth-1:0];
      r.fullness_q8      = full[tdqm_pkg::FullWidth-1:0];
      return r;
   endfunction

   function automatic void compare_field(string name, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MaxPrinted)
            $display("%0t ns: report %0d field %s expected %0d actual %0d",
                     $time, reports_checked, name, want, got);
      end
   endfunction

   // --------------------------------------------------------------------------
   // Monitor: sample both channels and the capacity port at the rising edge.
   // Check the returned report first, then predict the newly accepted tick.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_report_type  exp_r;
      typed_fields_type typed;
      if (reset) begin
         q_capacity  = tdqm_pkg::CapacityReset;
         q_held      = 0;
         q_peak      = 0;
         q_lost      = 0;
         q_ovf_ticks = 0;
         q_unf_ticks = 0;
         q_occ_sum   = 0;
         q_ticks     = 0;
      end else begin
         if (csr_wr_en)
            q_capacity = csr_wr_data;

         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxPrinted)
                  $display("%0t ns: unexpected report, expected none, actual data %h",
                           $time, rsp_tdata);
            end else begin
               exp_r = expected_reports.pop_front();
               compare_field("occupancy", 64'(exp_r.occupancy),
                             64'(rsp_tdata[10:0]));
               compare_field("overflow_now", 64'(exp_r.overflow_now),
                             64'(rsp_tdata[11]));
               compare_field("underflow_now", 64'(exp_r.underflow_now),
                             64'(rsp_tdata[12]));
               compare_field("dropped_now", 64'(exp_r.dropped_now),
                             64'(rsp_tdata[22:13]));
               compare_field("max_occupancy", 64'(exp_r.max_occupancy),
                             64'(rsp_tdata[33:23]));
               compare_field("total_lost", 64'(exp_r.total_lost),
                             64'(rsp_tdata[65:34]));
               compare_field("overflow_events", 64'(exp_r.overflow_events),
                             64'(rsp_tdata[97:66]));
               compare_field("underflow_events", 64'(exp_r.underflow_events),
                             64'(rsp_tdata[129:98]));
               compare_field("avg_occupancy", 64'(exp_r.avg_occupancy),
                             64'(rsp_tdata[140:130]));
               compare_field("loss_rate_q8", 64'(exp_r.loss_rate_q8),
                             64'(rsp_tdata[158:141]));
               compare_field("fullness_q8", 64'(exp_r.fullness_q8),
                             64'(rsp_tdata[173:159]));
               reports_checked++;
            end
         end

         if (req_tvalid && req_tready) begin
            exp_r = advance_queue_stats(req_tdata[9:0], req_tdata[19:10]);
            // directed rows carry hand-typed values for the per-tick fields
            if (typed_fields_q.size() != 0) begin
               typed = typed_fields_q.pop_front();
               if (typed.known) begin
                  exp_r.occupancy     = typed.occ;
                  exp_r.overflow_now  = typed.ovf;
                  exp_r.underflow_now = typed.unf;
                  exp_r.dropped_now   = typed.dropped;
               end
            end
            expected_reports = {expected_reports, exp_r};
            requests_taken++;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: stop the run when no handshake of any kind happens for too long
   // --------------------------------------------------------------------------
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t ns: no handshake for %0d cycles, %0d reports outstanding",
                  $time, QuietLimit, expected_reports.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off on request
   // --------------------------------------------------------------------------
   initial begin
      int stalls_served;
      int hold_left;
      stalls_served = 0;
      hold_left     = 0;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stalls_asked != stalls_served) begin
            stalls_served = long_stalls_asked;
            hold_left     = LongStall;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Sender tasks: all run on the falling edge
   // --------------------------------------------------------------------------

   // Offer one tick; idle first at random. Return at the falling edge after
   // acceptance with tvalid still high, so the next tick can follow at once.
   task automatic offer_tick(logic [tdqm_pkg::DropWidth-1:0] arr,
                             logic [tdqm_pkg::DropWidth-1:0] dep);
      int seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= tdqm_pkg::ReqDataWidth'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, dep, arr};
      seen = requests_taken;
      do
         @(negedge clock);
      while (requests_taken == seen);
   endtask

   // Drop valid and hold until every outstanding report has been returned.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (expected_reports.size() != 0);
   endtask

   // Write the capacity register while the monitor is idle.
   task automatic set_capacity(logic [tdqm_pkg::CountWidth-1:0] value);
      drain_reports();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= tdqm_pkg::CountWidth'($urandom);
      capacity_writes++;
      @(negedge clock);
   endtask

   // Pick a tick that exercises the current fill level: mostly traffic scaled
   // to the capacity, plus fills, drains, exact empties and raw noise.
   task automatic offer_random_tick();
      longint unsigned cap;
      int unsigned     span;
      int unsigned     arr;
      int unsigned     dep;
      int unsigned     pick;
      cap  = capacity_in_force();
      span = (cap > 64'd1023) ? 32'd1023 : 32'(cap);
      pick = $urandom_range(9);
      case (pick) inside
         0: begin
            arr = $urandom_range(1023);
            dep = $urandom_range(1023);
         end
         [1:3]: begin
            arr = $urandom_range(span / 3 + 1);
            dep = $urandom_range(span / 3 + 1);
         end
         4: begin
            arr = $urandom_range(1023);
            dep = 0;
         end
         5: begin
            arr = 0;
            dep = $urandom_range(span);
         end
         6: begin
            // drain exactly what will be held
            arr = $urandom_range(span);
            dep = 32'((q_held + 64'(arr) > cap) ? ((q_held > cap) ? q_held : cap)
                                                 : q_held + 64'(arr));
            if (dep > 1023)
               dep = 1023;
         end
         default: begin
            arr = $urandom_range(span);
            dep = $urandom_range(span);
         end
      endcase
      offer_tick(arr[tdqm_pkg::DropWidth-1:0], dep[tdqm_pkg::DropWidth-1:0]);
   endtask

   // --------------------------------------------------------------------------
   // Directed table, read off the queue rules for the typed rows
   // --------------------------------------------------------------------------
   stim_row_type directed_rows[] = '{
      // after reset, capacity 100
      '{ROW_TICK,            0,    0, 1,    0, 0, 0,    0},
      '{ROW_TICK,         1023,    0, 1,  100, 1, 0,  923},
      '{ROW_TICK,            0,  100, 1,    0, 0, 0,    0},  // exact drain
      '{ROW_TICK,           50, 1023, 1,    0, 0, 1,    0},
      '{ROW_TICK,          100,    0, 1,  100, 0, 0,    0},  // exact fill
      '{ROW_TICK,            1,    0, 1,  100, 1, 0,    1},
      // capacity lowered below the held count
      '{ROW_SET_CAPACITY,   10,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,            0,    0, 1,  100, 1, 0,    0},
      '{ROW_TICK,            5,    3, 1,   97, 1, 0,    5},
      // zero acts as one
      '{ROW_SET_CAPACITY,    0,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,            0, 1023, 1,    0, 1, 1,    0},
      '{ROW_TICK,            2,    0, 1,    1, 1, 0,    1},
      // all ones clamps to the largest capacity
      '{ROW_SET_CAPACITY, 2047,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,         1023,    0, 1, 1024, 0, 0,    0},
      '{ROW_TICK,         1023, 1023, 1,    1, 1, 0, 1023},
      '{ROW_TICK,         1023,    0, 1, 1024, 0, 0,    0},
      '{ROW_TICK,          682,  341, 0,    0, 0, 0,    0},
      '{ROW_TICK,          341,  682, 0,    0, 0, 0,    0},
      '{ROW_SET_CAPACITY, 1024,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,          512, 1023, 0,    0, 0, 0,    0},
      '{ROW_SET_CAPACITY,    1,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,            1,    1, 0,    0, 0, 0,    0},
      '{ROW_TICK,            1,    0, 0,    0, 0, 0,    0},
      '{ROW_TICK,            1,    0, 0,    0, 0, 0,    0}
   };

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      typed_fields_type                typed;
      logic [tdqm_pkg::CountWidth-1:0] capacity_plan[12];
      int                              send_pct_of[3];
      int                              rsp_pct_of[3];

      req_tvalid        = 1'b0;
      req_tdata         = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      reset             = 1'b1;
      requests_taken    = 0;
      reports_checked   = 0;
      mismatches        = 0;
      capacity_writes   = 0;
      long_stalls_asked = 0;
      send_pct_of       = '{12, 67, 0};
      rsp_pct_of        = '{67, 12, 0};
      send_idle_pct     = send_pct_of[0];
      rsp_idle_pct      = rsp_pct_of[0];

      // settings for the random part: extremes, clamped values and a few picks
      capacity_plan = '{11'd1024, 11'd1, 11'd300,
                        tdqm_pkg::CountWidth'($urandom_range(2047)),
                        11'd2047, 11'd37, 11'd0,
                        tdqm_pkg::CountWidth'($urandom_range(2047)),
                        11'd2, 11'd700, 11'd5, 11'd1536};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SET_CAPACITY) begin
            set_capacity(directed_rows[i].a[tdqm_pkg::CountWidth-1:0]);
         end else begin
            typed.known   = directed_rows[i].known;
            typed.occ     = directed_rows[i].occ[tdqm_pkg::CountWidth-1:0];
            typed.ovf     = directed_rows[i].ovf;
            typed.unf     = directed_rows[i].unf;
            typed.dropped = directed_rows[i].dropped[tdqm_pkg::DropWidth-1:0];
            typed_fields_q = {typed_fields_q, typed};
            offer_tick(directed_rows[i].a[tdqm_pkg::DropWidth-1:0],
                       directed_rows[i].b[tdqm_pkg::DropWidth-1:0]);
         end
      end

      // random ticks: three idling patterns, four capacity settings each
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pct_of[phase];
         rsp_idle_pct  = rsp_pct_of[phase];
         for (int sub = 0; sub < 4; sub++) begin
            set_capacity(capacity_plan[phase * 4 + sub]);
            // hold the receiver off while ticks keep coming, so input stalls
            if (phase == 2 && sub == 0)
               long_stalls_asked++;
            for (int n = 0; n < SubPhaseTicks; n++)
               offer_random_tick();
         end
      end

      // wait for the last reports, then give stray ones time to show up
      drain_reports();
      repeat (SettleCycles) @(negedge clock);
      if (expected_reports.size() != 0) begin
         mismatches++;
         $display("%0t ns: %0d reports never returned", $time, expected_reports.size());
      end

      $display("Covered %0d ticks under %0d capacity settings: %0d overflow ticks,",
               q_ticks, capacity_writes, q_ovf_ticks);
      $display("%0d underflow ticks, %0d packets dropped, %0d reports compared.",
               q_unf_ticks, q_lost, reports_checked);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
